// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// both macros expect clk and rst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fft2d_pkg.sv
// ----------------------------------------------------------------------------
// fft2d_pkg
// Types, widths and the quarter-wave twiddle table of the 2-D radix-2 FFT.
// ----------------------------------------------------------------------------
package fft2d_pkg;

    localparam int LOG_COLS_DEF = 5;
    localparam int LOG_ROWS_DEF = 5;

    localparam int INDEX_W  = 10;
    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 40;
    localparam int FRAC_W   = 8;
    localparam int LG_W     = 4;

    // twiddles are Q1.16, carried as 18-bit signed
    localparam int TW_W     = 17;
    localparam int W_W      = 18;
    localparam int ROM_LOG  = 10;
    localparam int ROM_QUARTER = 256;
    localparam int M_W      = ROM_LOG;

    // data word split in two 20-bit halves for the shared multiplier
    localparam int HALF_W   = 20;
    localparam int OPX_W    = HALF_W + 1;
    localparam int PROD_W   = W_W + OPX_W;
    localparam int ACC_W    = 58;
    localparam int TW_SHIFT = 16;
    localparam int T_W      = ACC_W - TW_SHIFT;
    localparam int SUM_W    = T_W + 1;
    localparam int MAC_STEPS = 8;
    localparam int STEP_W   = 3;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] sample_real;
        logic signed [SAMPLE_W-1:0] sample_imag;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_real;
        logic signed [DATA_W-1:0] result_imag;
    } rsp_t;

    // one multiply step of the shared unit
    typedef struct packed {
        logic valid;
        logic hi;
        logic first;
        logic dest_im;
    } mac_ctl_t;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
    localparam logic [63:0] TAYLOR_DIV [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    localparam int TW_ROM_W = (ROM_QUARTER + 1) * TW_W;

    // cos(pi*k/512) in Q1.16 for k in 0..256, by an integer series in Q30
    function automatic logic [TW_ROM_W-1:0] build_tw_rom();
        logic [TW_ROM_W-1:0] rom;
        logic [63:0]         x;
        logic [63:0]         x2;
        logic [63:0]         term;
        logic signed [63:0]  sum;
        rom = '0;
        for (int k = 0; k <= ROM_QUARTER; k++) begin
            x    = ((PI_Q62 >> 9) * 64'(k)) >> 32;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = $signed(term);
            for (int t = 1; t <= 12; t++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[t-1];
                if ((t & 1) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = '0;
            rom[k*TW_W +: TW_W] = TW_W'((sum + 64'sd8192) >>> 14);
        end
        return rom;
    endfunction

    localparam logic [TW_ROM_W-1:0] TW_ROM = build_tw_rom();

endpackage

// File: rtl/fft_2d_radix2_core.sv
// ----------------------------------------------------------------------------
// fft_2d_radix2_core
// Complex image store with an in-place row-column radix-2 FFT sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                        | transfer when
//  --------+--------------------------------+-------------------------------
//  req     | req_valid, req_stall, req      | req_valid && !req_stall
//  rsp     | rsp_valid, rsp_stall, rsp      | rsp_valid && !rsp_stall
//  cfg     | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
//  write: straight into the store; read: store register, then result register.
//  transform, per line of n points: bit reversal reads a kept element, reads and
//  writes each of a swapped pair; a butterfly reads both legs, makes 8 partial
//  products on the shared multiplier, writes both; forward scaling reads, writes.
//  the store (one read port, one write port a cycle) sets the load steps.
//  reset clears control only; the store holds junk until written.
//  req stalls while a transform or a read runs or a result waits in rsp.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fft_2d_radix2_core #(
    parameter int LOG_COLS = fft2d_pkg::LOG_COLS_DEF,
    parameter int LOG_ROWS = fft2d_pkg::LOG_ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  fft2d_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output fft2d_pkg::rsp_t   rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int LM    = (LOG_COLS > LOG_ROWS) ? LOG_COLS : LOG_ROWS;
    localparam int FL    = LOG_COLS + LOG_ROWS;
    localparam int DEPTH = 1 << FL;
    localparam bit ALL_IN_RANGE = FL >= fft2d_pkg::INDEX_W;
    localparam logic [fft2d_pkg::STEP_W-1:0] STEP_LAST =
        fft2d_pkg::STEP_W'(fft2d_pkg::MAC_STEPS - 1);
    localparam int DW = fft2d_pkg::DATA_W;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_RD_RESP = 15'b000000000000010,
        ST_BR_RD0  = 15'b000000000000100,
        ST_BR_RD1  = 15'b000000000001000,
        ST_BR_WR0  = 15'b000000000010000,
        ST_BR_WR1  = 15'b000000000100000,
        ST_BF_RD0  = 15'b000000001000000,
        ST_BF_RD1  = 15'b000000010000000,
        ST_BF_MUL  = 15'b000000100000000,
        ST_BF_DRN  = 15'b000001000000000,
        ST_BF_RND  = 15'b000010000000000,
        ST_BF_WR0  = 15'b000100000000000,
        ST_BF_WR1  = 15'b001000000000000,
        ST_SC_RD   = 15'b010000000000000,
        ST_SC_WR   = 15'b100000000000000
    } state_t;

    // store
    logic signed [DW-1:0] mem_re [DEPTH];
    logic signed [DW-1:0] mem_im [DEPTH];
    logic signed [DW-1:0] rd_re_q;
    logic signed [DW-1:0] rd_im_q;
    logic [FL-1:0]        rd_addr;
    logic [FL-1:0]        wr_addr;
    logic                 wr_en;
    logic signed [DW-1:0] wr_re;
    logic signed [DW-1:0] wr_im;

    // sequencer state
    state_t                         state_reg, state_next;
    logic                           pass_reg, pass_next;
    logic [LM-1:0]                  line_reg, line_next;
    logic [LM-1:0]                  e_reg, e_next;
    logic [fft2d_pkg::LG_W-1:0]     sl_reg, sl_next;
    logic [fft2d_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                           inverse_reg;
    logic                           rng_reg, rng_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    fft2d_pkg::rsp_t                rsp_reg, rsp_next;

    // operand registers
    logic signed [DW-1:0]             a_re_reg, a_im_reg;
    logic signed [DW-1:0]             x_re_reg, x_im_reg;
    logic signed [fft2d_pkg::W_W-1:0] w_re_reg, w_im_reg, nw_im_reg;
    logic signed [fft2d_pkg::T_W-1:0] t_re_reg, t_im_reg;

    // addressing
    logic [fft2d_pkg::LG_W-1:0] lg;
    logic [fft2d_pkg::LG_W-1:0] lg_line;
    logic [LM:0]                lim_pts;
    logic [LM:0]                lim_lines;
    logic [LM-1:0]              nmask;
    logic [LM-1:0]              lmask;
    logic [LM-1:0]              half;
    logic [LM-1:0]              hmask;
    logic [LM-1:0]              bf_i;
    logic [LM-1:0]              bf_p;
    logic [LM-1:0]              rev_full;
    logic [LM-1:0]              br_r;
    logic                       br_swap;
    logic [fft2d_pkg::M_W-1:0]  tw_m;
    logic [8:0]                 m9;
    logic [fft2d_pkg::M_W-1:0]  m_ext;
    logic [8:0]                 idx_c;
    logic [8:0]                 idx_s;
    logic signed [fft2d_pkg::W_W-1:0] rom_c;
    logic signed [fft2d_pkg::W_W-1:0] rom_s;
    logic signed [fft2d_pkg::W_W-1:0] tw_c;
    logic signed [fft2d_pkg::W_W-1:0] tw_wi;

    // arithmetic
    fft2d_pkg::mac_ctl_t                   mac_ctl;
    logic signed [fft2d_pkg::W_W-1:0]      mac_w;
    logic signed [fft2d_pkg::OPX_W-1:0]    mac_x;
    logic signed [DW-1:0]                  mac_xsel;
    logic signed [fft2d_pkg::ACC_W-1:0]    acc_re;
    logic signed [fft2d_pkg::ACC_W-1:0]    acc_im;
    logic signed [fft2d_pkg::ACC_W-1:0]    rnd_re;
    logic signed [fft2d_pkg::ACC_W-1:0]    rnd_im;
    logic signed [fft2d_pkg::SUM_W-1:0]    sum_a_re, sum_a_im, sum_p_re, sum_p_im;
    logic signed [DW:0]                    sc_bit;
    logic signed [DW:0]                    sc_re, sc_im;

    logic req_fire;
    logic in_range;

    function automatic logic [FL-1:0] line_addr(input logic pass, input logic [LM-1:0] ln,
                                                input logic [LM-1:0] el);
        if (pass)
            return {el[LOG_ROWS-1:0], ln[LOG_COLS-1:0]};
        else
            return {ln[LOG_ROWS-1:0], el[LOG_COLS-1:0]};
    endfunction

    function automatic logic signed [DW-1:0] sat40(input logic signed [fft2d_pkg::SUM_W-1:0] v);
        logic signed [fft2d_pkg::SUM_W-1:0] hi_lim;
        logic signed [fft2d_pkg::SUM_W-1:0] lo_lim;
        hi_lim = fft2d_pkg::SUM_W'({1'b0, {(DW-1){1'b1}}});
        lo_lim = -hi_lim - fft2d_pkg::SUM_W'(1);
        if (v > hi_lim)
            return {1'b0, {(DW-1){1'b1}}};
        else if (v < lo_lim)
            return {1'b1, {(DW-1){1'b0}}};
        else
            return DW'(v);
    endfunction

    function automatic logic [fft2d_pkg::TW_W-1:0] tw_rom(input logic [8:0] k);
        return fft2d_pkg::TW_ROM[k*fft2d_pkg::TW_W +: fft2d_pkg::TW_W];
    endfunction

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE) || rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_range = ALL_IN_RANGE || (32'(req.index) < DEPTH);
    end

    // ---------------------------------------------------------------- indices
    always_comb
    begin
        lg        = pass_reg ? fft2d_pkg::LG_W'(LOG_ROWS) : fft2d_pkg::LG_W'(LOG_COLS);
        lg_line   = pass_reg ? fft2d_pkg::LG_W'(LOG_COLS) : fft2d_pkg::LG_W'(LOG_ROWS);
        lim_pts   = ((LM+1)'(1) << lg) - 1'b1;
        lim_lines = ((LM+1)'(1) << lg_line) - 1'b1;
        nmask     = lim_pts[LM-1:0];
        lmask     = lim_lines[LM-1:0];

        half  = LM'(1) << (sl_reg - 1'b1);
        hmask = half - 1'b1;
        // butterfly k: insert a zero at bit sl-1 for the top leg
        bf_i  = ((e_reg & ~hmask) << 1) | (e_reg & hmask);
        bf_p  = bf_i | half;

        for (int b = 0; b < LM; b++)
            rev_full[LM-1-b] = e_reg[b];
        br_r    = rev_full >> (LM - lg);
        br_swap = e_reg < br_r;

        tw_m  = fft2d_pkg::M_W'(e_reg & hmask) << (fft2d_pkg::ROM_LOG - sl_reg);
        m9    = tw_m[8:0];
        m_ext = fft2d_pkg::M_W'(m9);
        if (m_ext <= fft2d_pkg::M_W'(fft2d_pkg::ROM_QUARTER))
        begin
            idx_c = m9;
            idx_s = 9'(fft2d_pkg::M_W'(fft2d_pkg::ROM_QUARTER) - m_ext);
        end
        else
        begin
            idx_c = 9'(fft2d_pkg::M_W'(2 * fft2d_pkg::ROM_QUARTER) - m_ext);
            idx_s = 9'(m_ext - fft2d_pkg::M_W'(fft2d_pkg::ROM_QUARTER));
        end
        rom_c = $signed({1'b0, tw_rom(idx_c)});
        rom_s = $signed({1'b0, tw_rom(idx_s)});
        tw_c  = (m_ext <= fft2d_pkg::M_W'(fft2d_pkg::ROM_QUARTER)) ? rom_c : -rom_c;
        tw_wi = inverse_reg ? rom_s : -rom_s;
    end

    // ---------------------------------------------------------------- shared multiplier
    always_comb
    begin
        mac_ctl.valid   = (state_reg == ST_BF_MUL);
        mac_ctl.hi      = step_reg[0];
        mac_ctl.first   = (step_reg[1:0] == 2'b00);
        mac_ctl.dest_im = step_reg[2];
        // re: wr*xr - wi*xi, im: wi*xr + wr*xi
        unique case (step_reg[2:1])
            2'b00:   mac_w = w_re_reg;
            2'b01:   mac_w = nw_im_reg;
            2'b10:   mac_w = w_im_reg;
            2'b11:   mac_w = w_re_reg;
            default: mac_w = w_re_reg;
        endcase
        mac_xsel = step_reg[1] ? x_im_reg : x_re_reg;
        if (step_reg[0])
            mac_x = $signed({mac_xsel[DW-1], mac_xsel[DW-1:fft2d_pkg::HALF_W]});
        else
            mac_x = $signed({1'b0, mac_xsel[fft2d_pkg::HALF_W-1:0]});
    end

    fft2d_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .op_w   (mac_w),
        .op_x   (mac_x),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    always_comb
    begin
        rnd_re   = acc_re + fft2d_pkg::ACC_W'(1 << (fft2d_pkg::TW_SHIFT - 1));
        rnd_im   = acc_im + fft2d_pkg::ACC_W'(1 << (fft2d_pkg::TW_SHIFT - 1));
        sum_a_re = fft2d_pkg::SUM_W'(a_re_reg) + fft2d_pkg::SUM_W'(t_re_reg);
        sum_a_im = fft2d_pkg::SUM_W'(a_im_reg) + fft2d_pkg::SUM_W'(t_im_reg);
        sum_p_re = fft2d_pkg::SUM_W'(a_re_reg) - fft2d_pkg::SUM_W'(t_re_reg);
        sum_p_im = fft2d_pkg::SUM_W'(a_im_reg) - fft2d_pkg::SUM_W'(t_im_reg);
        sc_bit   = (DW+1)'(1) <<< (lg - 1'b1);
        sc_re    = (DW+1)'(rd_re_q) + sc_bit;
        sc_im    = (DW+1)'(rd_im_q) + sc_bit;
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        line_next      = line_reg;
        e_next         = e_reg;
        sl_next        = sl_reg;
        step_next      = step_reg;
        rng_next       = rng_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        rd_addr        = FL'(req.index);
        wr_en          = 1'b0;
        wr_addr        = FL'(req.index);
        wr_re          = DW'(req.sample_real) <<< fft2d_pkg::FRAC_W;
        wr_im          = DW'(req.sample_imag) <<< fft2d_pkg::FRAC_W;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.opcode)
                        fft2d_pkg::OP_WRITE:
                        begin
                            wr_en = in_range;
                        end
                        fft2d_pkg::OP_RUN:
                        begin
                            pass_next  = 1'b0;
                            line_next  = '0;
                            e_next     = '0;
                            state_next = ST_BR_RD0;
                        end
                        fft2d_pkg::OP_READ:
                        begin
                            rng_next   = in_range;
                            state_next = ST_RD_RESP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_RESP:
            begin
                rsp_valid_next = 1'b1;
                rsp_next.result_real = rng_reg ? rd_re_q : '0;
                rsp_next.result_imag = rng_reg ? rd_im_q : '0;
                state_next = ST_IDLE;
            end
            ST_BR_RD0, ST_BR_WR1:
            begin
                rd_addr = line_addr(pass_reg, line_reg, e_reg);
                if (state_reg == ST_BR_WR1)
                begin
                    wr_en   = 1'b1;
                    wr_addr = line_addr(pass_reg, line_reg, br_r);
                    wr_re   = a_re_reg;
                    wr_im   = a_im_reg;
                end
                if (state_reg == ST_BR_RD0 && br_swap)
                begin
                    state_next = ST_BR_RD1;
                end
                else if (e_reg == nmask)
                begin
                    e_next     = '0;
                    sl_next    = fft2d_pkg::LG_W'(1);
                    state_next = ST_BF_RD0;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_BR_RD0;
                end
            end
            ST_BR_RD1:
            begin
                rd_addr    = line_addr(pass_reg, line_reg, br_r);
                state_next = ST_BR_WR0;
            end
            ST_BR_WR0:
            begin
                wr_en      = 1'b1;
                wr_addr    = line_addr(pass_reg, line_reg, e_reg);
                wr_re      = rd_re_q;
                wr_im      = rd_im_q;
                state_next = ST_BR_WR1;
            end
            ST_BF_RD0:
            begin
                rd_addr    = line_addr(pass_reg, line_reg, bf_p);
                state_next = ST_BF_RD1;
            end
            ST_BF_RD1:
            begin
                rd_addr    = line_addr(pass_reg, line_reg, bf_i);
                step_next  = '0;
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = ST_BF_DRN;
            end
            ST_BF_DRN:
            begin
                state_next = ST_BF_RND;
            end
            ST_BF_RND:
            begin
                state_next = ST_BF_WR0;
            end
            ST_BF_WR0:
            begin
                wr_en      = 1'b1;
                wr_addr    = line_addr(pass_reg, line_reg, bf_i);
                wr_re      = sat40(sum_a_re);
                wr_im      = sat40(sum_a_im);
                state_next = ST_BF_WR1;
            end
            ST_BF_WR1:
            begin
                wr_en   = 1'b1;
                wr_addr = line_addr(pass_reg, line_reg, bf_p);
                wr_re   = sat40(sum_p_re);
                wr_im   = sat40(sum_p_im);
                if (e_reg == (nmask >> 1))
                begin
                    e_next = '0;
                    if (sl_reg == lg)
                    begin
                        if (!inverse_reg)
                            state_next = ST_SC_RD;
                        else if (line_reg == lmask)
                        begin
                            line_next  = '0;
                            pass_next  = 1'b1;
                            state_next = pass_reg ? ST_IDLE : ST_BR_RD0;
                        end
                        else
                        begin
                            line_next  = line_reg + 1'b1;
                            state_next = ST_BR_RD0;
                        end
                    end
                    else
                    begin
                        sl_next    = sl_reg + 1'b1;
                        state_next = ST_BF_RD0;
                    end
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_BF_RD0;
                end
            end
            ST_SC_RD:
            begin
                rd_addr    = line_addr(pass_reg, line_reg, e_reg);
                state_next = ST_SC_WR;
            end
            ST_SC_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = line_addr(pass_reg, line_reg, e_reg);
                wr_re   = DW'(sc_re >>> lg);
                wr_im   = DW'(sc_im >>> lg);
                if (e_reg == nmask)
                begin
                    e_next = '0;
                    if (line_reg == lmask)
                    begin
                        line_next  = '0;
                        pass_next  = 1'b1;
                        state_next = pass_reg ? ST_IDLE : ST_BR_RD0;
                    end
                    else
                    begin
                        line_next  = line_reg + 1'b1;
                        state_next = ST_BR_RD0;
                    end
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_SC_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 1'b0;
            line_reg      <= '0;
            e_reg         <= '0;
            sl_reg        <= '0;
            step_reg      <= '0;
            rng_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            inverse_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            line_reg      <= line_next;
            e_reg         <= e_next;
            sl_reg        <= sl_next;
            step_reg      <= step_next;
            rng_reg       <= rng_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
                inverse_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (state_reg == ST_BF_RD0)
        begin
            w_re_reg  <= tw_c;
            w_im_reg  <= tw_wi;
            nw_im_reg <= -tw_wi;
        end
        if (state_reg == ST_BF_RD1)
        begin
            x_re_reg <= rd_re_q;
            x_im_reg <= rd_im_q;
        end
        // top leg arrives in the first multiply cycle, swap source in bit reversal
        if (state_reg == ST_BR_RD1 || (state_reg == ST_BF_MUL && step_reg == '0))
        begin
            a_re_reg <= rd_re_q;
            a_im_reg <= rd_im_q;
        end
        if (state_reg == ST_BF_RND)
        begin
            t_re_reg <= fft2d_pkg::T_W'(rnd_re >>> fft2d_pkg::TW_SHIFT);
            t_im_reg <= fft2d_pkg::T_W'(rnd_im >>> fft2d_pkg::TW_SHIFT);
        end
    end

    // store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_re[wr_addr] <= wr_re;
            mem_im[wr_addr] <= wr_im;
        end
        rd_re_q <= mem_re[rd_addr];
        rd_im_q <= mem_im[rd_addr];
    end

    // ---------------------------------------------------------------- checks
    `ASSERT_IMPL(a_rsp_from_read, $rose(rsp_valid_reg), $past(state_reg == ST_RD_RESP),
                 "result raised without a read")
    `ASSERT_IMPL(a_stage_bound, state_reg == ST_BF_MUL, sl_reg != '0 && sl_reg <= lg,
                 "butterfly stage out of range")
    `ASSERT_IMPL(a_bf_pair, state_reg == ST_BF_RD0, bf_p != bf_i && (bf_p & nmask) == bf_p,
                 "butterfly legs collide or leave the line")
    `ASSERT_NEXT(a_mac_drain, state_reg == ST_BF_MUL && step_reg == STEP_LAST,
                 state_reg == ST_BF_DRN, "multiply steps did not drain")

endmodule

// File: rtl/fft2d_mac.sv
// ----------------------------------------------------------------------------
// fft2d_mac
// Shared multiplier with accumulators for the complex twiddle products.
// ----------------------------------------------------------------------------
module fft2d_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  fft2d_pkg::mac_ctl_t                    ctl,
    input  logic signed [fft2d_pkg::W_W-1:0]       op_w,
    input  logic signed [fft2d_pkg::OPX_W-1:0]     op_x,
    output logic signed [fft2d_pkg::ACC_W-1:0]     acc_re,
    output logic signed [fft2d_pkg::ACC_W-1:0]     acc_im
);

    logic signed [fft2d_pkg::PROD_W-1:0] prod_reg;
    fft2d_pkg::mac_ctl_t                 tag_reg;
    logic signed [fft2d_pkg::ACC_W-1:0]  acc_re_reg;
    logic signed [fft2d_pkg::ACC_W-1:0]  acc_im_reg;
    logic signed [fft2d_pkg::ACC_W-1:0]  term;
    logic signed [fft2d_pkg::ACC_W-1:0]  base;
    logic signed [fft2d_pkg::ACC_W-1:0]  acc_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_w * op_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= ctl;
        end
    end

    always_comb
    begin
        term = fft2d_pkg::ACC_W'(prod_reg);
        if (tag_reg.hi)
            term = term <<< fft2d_pkg::HALF_W;
        if (tag_reg.first)
            base = '0;
        else if (tag_reg.dest_im)
            base = acc_im_reg;
        else
            base = acc_re_reg;
        acc_next = base + term;
    end

    always_ff @(posedge clk)
    begin
        if (tag_reg.valid && tag_reg.dest_im)
            acc_im_reg <= acc_next;
        if (tag_reg.valid && !tag_reg.dest_im)
            acc_re_reg <= acc_next;
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule
